/* hw/rtl/sector_read_retry_sequencer_defines.svh */
// Assertion macros used by the checker file srrs_checker.sv.
`ifndef SECTOR_READ_RETRY_SEQUENCER_DEFINES_SVH
`define SECTOR_READ_RETRY_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SRRS_ASSERT_IMP(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) \
    else $error("srrs assertion failed");

// Next-cycle implication, disabled during reset.
`define SRRS_ASSERT_NXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) \
    else $error("srrs assertion failed");

// Next-cycle implication that is also checked across reset.
`define SRRS_ASSERT_ALWAYS_NXT(lbl, c, a, b) \
  lbl: assert property (@(posedge c) (a) |=> (b)) \
    else $error("srrs assertion failed");

`endif

/* hw/rtl/srrs_pkg.sv */
`default_nettype none
package srrs_pkg;

  localparam int unsigned MAX_SECTORS_DEF = 65535;

  localparam logic [7:0]  TIMEOUT_RESET  = 8'd180;
  localparam logic [7:0]  COOLDOWN_RESET = 8'd60;
  localparam logic [9:0]  WORDS_RAW      = 10'd585;
  localparam logic [9:0]  WORDS_STD      = 10'd512;
  localparam logic [16:0] ABORTED_MARK   = 17'h1FFFF;
  localparam logic [7:0]  TICK_MAX       = 8'd255;
  localparam int unsigned RAW_MODE_BIT   = 5;

  localparam logic [2:0] OP_START  = 3'd0;
  localparam logic [2:0] OP_READY  = 3'd1;
  localparam logic [2:0] OP_ERROR  = 3'd2;
  localparam logic [2:0] OP_TICK   = 3'd3;
  localparam logic [2:0] OP_BREAK  = 3'd4;
  localparam logic [2:0] OP_POLL   = 3'd5;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_SEEK  = 2'd2;
  localparam logic [1:0] CMD_PAUSE = 2'd3;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_REFUSED  = 3'd1;
  localparam logic [2:0] ST_PENDING  = 3'd2;
  localparam logic [2:0] ST_COMPLETE = 3'd3;
  localparam logic [2:0] ST_ABORTED  = 3'd4;
  localparam logic [2:0] ST_FAILED   = 3'd5;
  localparam logic [2:0] ST_DRIVE    = 3'd6;
  localparam logic [2:0] ST_RETRYING = 3'd7;

  localparam logic [1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_COOLDOWN = 2'd1;
  localparam logic [1:0] REG_NOTIFY   = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] sector_count;
    logic [31:0] buffer_address;
    logic [7:0]  read_mode;
    logic [7:0]  attempt_limit;
    logic [18:0] start_sector;
    logic        drive_error;
  } srrs_in_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  command_mode;
    logic [18:0] command_sector;
    logic        copy_valid;
    logic [31:0] copy_address;
    logic [9:0]  copy_words;
    logic [2:0]  status;
    logic [15:0] pending_count;
    logic        notify;
    logic        notify_error;
  } srrs_out_t;

  typedef struct packed {
    logic [1:0] index;
    logic [7:0] data;
  } srrs_cfg_t;

  typedef struct packed {
    logic [7:0] timeout_ticks;
    logic [7:0] cooldown_ticks;
    logic       notify_enabled;
  } srrs_ctrl_t;

endpackage
`default_nettype wire

/* hw/rtl/srrs_ifs.sv */
`default_nettype none
interface srrs_in_if;
  import srrs_pkg::*;
  logic     valid;
  logic     ready;
  srrs_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srrs_out_if;
  import srrs_pkg::*;
  logic      valid;
  logic      ready;
  srrs_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srrs_cfg_if;
  import srrs_pkg::*;
  logic      valid;
  logic      ready;
  srrs_cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/sector_read_retry_sequencer.sv */
// Channel   Role    Handshake        Payload
// in_req    sink    valid / ready    srrs_in_t: one event, tick, break, poll or start
// out_rsp   source  valid / ready    srrs_out_t: one result per request
// cfg_wr    sink    valid / ready    srrs_cfg_t: register index and write data
//
// Throughput is one request per cycle while out_rsp.ready stays high; a request is held in
// the input register, and the state-update and result stage registers its result in out_r.
// Reset is synchronous and active low; config returns to 180 / 60 / off.
// A stalled result holds the output register; the input register still takes
// one more request, and in_req.ready drops only when both are full.
// cfg_wr is always ready; write only while no request is in flight.
`default_nettype none
module sector_read_retry_sequencer #(
  parameter int unsigned MAX_SECTORS = srrs_pkg::MAX_SECTORS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  srrs_in_if.sink   in_req,
  srrs_out_if.source out_rsp,
  srrs_cfg_if.sink  cfg_wr
);
  import srrs_pkg::*;

  srrs_in_t   s1_r;
  logic       s1_valid_r, s1_valid_nxt;
  srrs_out_t  out_r;
  logic       out_valid_r, out_valid_nxt;
  srrs_out_t  result;
  srrs_ctrl_t ctrl;
  logic       advance, fire, in_take;

  assign advance = !out_valid_r || out_rsp.ready;
  assign fire    = s1_valid_r && advance;
  assign in_req.ready = !s1_valid_r || advance;
  assign in_take = in_req.valid && in_req.ready;

  assign cfg_wr.ready = 1'b1;

  srrs_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cfg_wr.valid),
    .wr_req (cfg_wr.data),
    .ctrl   (ctrl)
  );

  srrs_engine #(
    .MAX_SECTORS (MAX_SECTORS)
  ) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_r),
    .ctrl   (ctrl),
    .result (result)
  );

  always_comb begin
    s1_valid_nxt = in_take ? 1'b1 : (fire ? 1'b0 : s1_valid_r);
    out_valid_nxt = fire ? 1'b1 : (out_rsp.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r <= in_req.data;
    end
    if (fire) begin
      out_r <= result;
    end
  end

  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_r;
endmodule
`default_nettype wire

/* hw/rtl/srrs_cfg_regs.sv */
`default_nettype none
module srrs_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  srrs_pkg::srrs_cfg_t wr_req,
  output srrs_pkg::srrs_ctrl_t ctrl
);
  import srrs_pkg::*;

  srrs_ctrl_t ctrl_r, ctrl_nxt;

  always_comb begin
    ctrl_nxt = ctrl_r;
    if (wr_en) begin
      case (wr_req.index)
        REG_TIMEOUT:  ctrl_nxt.timeout_ticks  = wr_req.data;
        REG_COOLDOWN: ctrl_nxt.cooldown_ticks = wr_req.data;
        REG_NOTIFY:   ctrl_nxt.notify_enabled = wr_req.data[0];
        default:      ctrl_nxt = ctrl_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.timeout_ticks  <= TIMEOUT_RESET;
      ctrl_r.cooldown_ticks <= COOLDOWN_RESET;
      ctrl_r.notify_enabled <= 1'b0;
    end else begin
      ctrl_r <= ctrl_nxt;
    end
  end

  assign ctrl = ctrl_r;
endmodule
`default_nettype wire

/* hw/rtl/srrs_engine.sv */
`default_nettype none
module srrs_engine #(
  parameter int unsigned MAX_SECTORS = srrs_pkg::MAX_SECTORS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  srrs_pkg::srrs_in_t   item,
  input  srrs_pkg::srrs_ctrl_t ctrl,
  output srrs_pkg::srrs_out_t  result
);
  import srrs_pkg::*;

  localparam logic [23:0] MaxSec = 24'(MAX_SECTORS);

  logic [16:0] pend_r, pend_nxt;
  logic [7:0]  att_r, att_nxt;
  logic [15:0] runlen_r, runlen_nxt;
  logic [18:0] runstart_r, runstart_nxt;
  logic [31:0] waddr_r, waddr_nxt;
  logic [9:0]  swords_r, swords_nxt;
  logic [7:0]  elapsed_r, elapsed_nxt;
  logic        cool_r, cool_nxt;

  logic        aborted, active, listening, timer_out;
  logic        aborted_nxt, active_nxt;
  logic [7:0]  limit_sel;
  logic [15:0] count_clamped;
  logic [2:0]  idle_st, idle_st_nxt;
  srrs_out_t   res;

  always_comb begin
    aborted   = pend_r == ABORTED_MARK;
    active    = (pend_r != '0) && !aborted;
    listening = (pend_r != '0) && !cool_r;
    limit_sel = cool_r ? ctrl.cooldown_ticks : ctrl.timeout_ticks;
    timer_out = elapsed_r > limit_sel;
    idle_st   = aborted ? ST_ABORTED : ((pend_r == '0) ? ST_COMPLETE : ST_PENDING);
    count_clamped = ({8'd0, item.sector_count} > MaxSec) ? MaxSec[15:0]
                                                         : item.sector_count;
  end

  always_comb begin
    pend_nxt     = pend_r;
    att_nxt      = att_r;
    runlen_nxt   = runlen_r;
    runstart_nxt = runstart_r;
    waddr_nxt    = waddr_r;
    swords_nxt   = swords_r;
    elapsed_nxt  = elapsed_r;
    cool_nxt     = cool_r;
    res          = '0;
    res.status   = idle_st;
    case (item.operation)
      OP_START: begin
        if (active || (item.sector_count == '0) || (item.attempt_limit == '0)) begin
          res.status = ST_REFUSED;
        end else begin
          waddr_nxt    = item.buffer_address;
          elapsed_nxt  = '0;
          cool_nxt     = 1'b0;
          att_nxt      = item.attempt_limit - 8'd1;
          pend_nxt     = {1'b0, count_clamped};
          runlen_nxt   = count_clamped;
          runstart_nxt = item.start_sector;
          swords_nxt   = item.read_mode[RAW_MODE_BIT] ? WORDS_RAW : WORDS_STD;
          res.command      = CMD_READ;
          res.command_mode = item.read_mode;
          res.status       = ST_ACCEPTED;
        end
      end
      OP_READY, OP_ERROR: begin
        if (listening) begin
          if (aborted) begin
            res.command = CMD_PAUSE;
            cool_nxt    = 1'b1;
            elapsed_nxt = '0;
          end else if (item.operation == OP_READY) begin
            res.copy_valid   = 1'b1;
            res.copy_address = waddr_r;
            res.copy_words   = swords_r;
            waddr_nxt = waddr_r + {20'd0, swords_r, 2'b00};
            pend_nxt  = pend_r - 17'd1;
            if (pend_r != 17'd1) begin
              elapsed_nxt = '0;
            end else begin
              res.command = CMD_PAUSE;
              cool_nxt    = 1'b1;
              elapsed_nxt = '0;
              res.notify  = ctrl.notify_enabled;
            end
          end else begin
            res.command = CMD_PAUSE;
            cool_nxt    = 1'b1;
            elapsed_nxt = '0;
            if ((att_r == '0) && ctrl.notify_enabled) begin
              res.notify       = 1'b1;
              res.notify_error = 1'b1;
            end
          end
        end
      end
      OP_TICK: begin
        if (elapsed_r < TICK_MAX) begin
          elapsed_nxt = elapsed_r + 8'd1;
        end
      end
      OP_BREAK: begin
        if (active) begin
          pend_nxt = ABORTED_MARK;
        end
      end
      OP_POLL: begin
        if (active) begin
          if (timer_out) begin
            if (att_r == '0) begin
              pend_nxt   = '0;
              res.status = ST_FAILED;
            end else begin
              att_nxt      = att_r - 8'd1;
              runstart_nxt = runstart_r + {3'd0, runlen_r} - {3'd0, pend_r[15:0]};
              runlen_nxt   = pend_r[15:0];
              elapsed_nxt  = '0;
              cool_nxt     = 1'b0;
              res.command        = CMD_SEEK;
              res.command_sector = runstart_nxt;
              res.status         = ST_RETRYING;
            end
          end else if (item.drive_error) begin
            res.status = ST_DRIVE;
          end else begin
            res.status = ST_PENDING;
          end
        end
      end
      default: begin
        res.status = idle_st;
      end
    endcase

    aborted_nxt = pend_nxt == ABORTED_MARK;
    active_nxt  = (pend_nxt != '0) && !aborted_nxt;
    idle_st_nxt = aborted_nxt ? ST_ABORTED
                              : ((pend_nxt == '0) ? ST_COMPLETE : ST_PENDING);
    if ((item.operation == OP_BREAK) ||
        (((item.operation == OP_READY) || (item.operation == OP_ERROR)) && listening)) begin
      res.status = idle_st_nxt;
    end
    res.pending_count = active_nxt ? pend_nxt[15:0] : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= '0;
      att_r      <= '0;
      runlen_r   <= '0;
      runstart_r <= '0;
      waddr_r    <= '0;
      swords_r   <= WORDS_STD;
      elapsed_r  <= '0;
      cool_r     <= 1'b0;
    end else if (fire) begin
      pend_r     <= pend_nxt;
      att_r      <= att_nxt;
      runlen_r   <= runlen_nxt;
      runstart_r <= runstart_nxt;
      waddr_r    <= waddr_nxt;
      swords_r   <= swords_nxt;
      elapsed_r  <= elapsed_nxt;
      cool_r     <= cool_nxt;
    end
  end

  assign result = res;
endmodule
`default_nettype wire

/* hw/rtl/srrs_checker.sv */
`default_nettype none
`include "sector_read_retry_sequencer_defines.svh"
module srrs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input srrs_pkg::srrs_out_t out_data
);
  import srrs_pkg::*;

  `SRRS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `SRRS_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data))
  `SRRS_ASSERT_IMP(a_no_stall_ready, clk, rst_n, out_ready, in_ready)
  `SRRS_ASSERT_ALWAYS_NXT(a_reset_empty, clk, !rst_n, !out_valid)
  `SRRS_ASSERT_NXT(a_request_flows, clk, rst_n, in_valid && in_ready, in_ready || out_valid)
endmodule

bind sector_read_retry_sequencer srrs_checker u_srrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .out_data  (out_rsp.data)
);
`default_nettype wire

/* dv/srrs_result_checker.sv */
module srrs_result_checker (
  input  logic clk,
  input  logic rst_n,
  srrs_in_if   in_req,
  srrs_out_if  out_rsp,
  srrs_cfg_if  cfg_wr,
  output int   in_flight,
  output int   fail_count,
  output int   results_checked,
  output int   retries_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import srrs_pkg::*;

  logic [16:0] pending;
  logic [7:0]  attempts;
  logic [15:0] run_len;
  logic [18:0] run_first;
  logic [31:0] wr_addr;
  logic [9:0]  words;
  logic [7:0]  ticks;
  logic        cooling;
  logic [7:0]  timeout_lim;
  logic [7:0]  cooldown_lim;
  logic        notify_en;

  srrs_out_t due_results[$];
  int mismatches = 0;
  int checked = 0;
  int retries = 0;

  assign fail_count = mismatches;
  assign results_checked = checked;
  assign retries_seen = retries;

  function automatic logic job_active();
    return pending != '0 && pending != ABORTED_MARK;
  endfunction

  function automatic logic [2:0] job_status();
    if (pending == ABORTED_MARK) return ST_ABORTED;
    if (pending == '0) return ST_COMPLETE;
    return ST_PENDING;
  endfunction

  function automatic logic timer_out();
    return ticks > (cooling ? cooldown_lim : timeout_lim);
  endfunction

  function automatic void arm_cooldown();
    cooling = 1'b1;
    ticks = '0;
  endfunction

  function automatic srrs_out_t advance_read_job(srrs_in_t req);
    srrs_out_t rsp;
    logic listening;
    rsp = '0;
    rsp.status = job_status();
    listening = pending != '0 && !cooling;
    case (req.operation)
      OP_START: begin
        if (job_active() || req.sector_count == '0 || req.attempt_limit == '0) begin
          rsp.status = ST_REFUSED;
        end else begin
          wr_addr = req.buffer_address;
          ticks = '0;
          cooling = 1'b0;
          attempts = req.attempt_limit - 8'd1;
          pending = {1'b0, req.sector_count};
          run_len = req.sector_count;
          run_first = req.start_sector;
          words = req.read_mode[RAW_MODE_BIT] ? WORDS_RAW : WORDS_STD;
          rsp.command = CMD_READ;
          rsp.command_mode = req.read_mode;
          rsp.status = ST_ACCEPTED;
        end
      end
      OP_READY, OP_ERROR: begin
        if (listening) begin
          if (pending == ABORTED_MARK) begin
            rsp.command = CMD_PAUSE;
            arm_cooldown();
          end else if (req.operation == OP_READY) begin
            rsp.copy_valid = 1'b1;
            rsp.copy_address = wr_addr;
            rsp.copy_words = words;
            wr_addr = wr_addr + {20'b0, words, 2'b00};
            pending = pending - 17'd1;
            if (pending != '0) begin
              ticks = '0;
            end else begin
              rsp.command = CMD_PAUSE;
              arm_cooldown();
              rsp.notify = notify_en;
            end
          end else begin
            rsp.command = CMD_PAUSE;
            arm_cooldown();
            if (attempts == '0 && notify_en) begin
              rsp.notify = 1'b1;
              rsp.notify_error = 1'b1;
            end
          end
          rsp.status = job_status();
        end
      end
      OP_TICK: begin
        if (ticks != TICK_MAX) ticks = ticks + 8'd1;
      end
      OP_BREAK: begin
        if (job_active()) pending = ABORTED_MARK;
        rsp.status = job_status();
      end
      OP_POLL: begin
        if (job_active()) begin
          if (timer_out()) begin
            if (attempts == '0) begin
              pending = '0;
              rsp.status = ST_FAILED;
            end else begin
              attempts = attempts - 8'd1;
              run_first = 19'(32'(run_first) + 32'(run_len) - 32'(pending));
              run_len = pending[15:0];
              ticks = '0;
              cooling = 1'b0;
              rsp.command = CMD_SEEK;
              rsp.command_sector = run_first;
              rsp.status = ST_RETRYING;
              retries++;
            end
          end else if (req.drive_error) begin
            rsp.status = ST_DRIVE;
          end else begin
            rsp.status = ST_PENDING;
          end
        end
      end
      default: ;
    endcase
    rsp.pending_count = job_active() ? pending[15:0] : '0;
    return rsp;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void compare_result(srrs_out_t want, srrs_out_t got);
    check_field("command", 32'(want.command), 32'(got.command));
    check_field("command_mode", 32'(want.command_mode), 32'(got.command_mode));
    check_field("command_sector", 32'(want.command_sector), 32'(got.command_sector));
    check_field("copy_valid", 32'(want.copy_valid), 32'(got.copy_valid));
    check_field("copy_address", want.copy_address, got.copy_address);
    check_field("copy_words", 32'(want.copy_words), 32'(got.copy_words));
    check_field("status", 32'(want.status), 32'(got.status));
    check_field("pending_count", 32'(want.pending_count), 32'(got.pending_count));
    check_field("notify", 32'(want.notify), 32'(got.notify));
    check_field("notify_error", 32'(want.notify_error), 32'(got.notify_error));
  endfunction

  always @(posedge clk) begin
    srrs_out_t want;
    if (!rst_n) begin
      timeout_lim = TIMEOUT_RESET;
      cooldown_lim = COOLDOWN_RESET;
      notify_en = 1'b0;
      pending = '0;
      attempts = '0;
      run_len = '0;
      run_first = '0;
      wr_addr = '0;
      words = WORDS_STD;
      ticks = '0;
      cooling = 1'b0;
      due_results.delete();
    end else begin
      if (cfg_wr.valid && cfg_wr.ready) begin
        case (cfg_wr.data.index)
          REG_TIMEOUT:  timeout_lim = cfg_wr.data.data;
          REG_COOLDOWN: cooldown_lim = cfg_wr.data.data;
          REG_NOTIFY:   notify_en = cfg_wr.data.data[0];
          default: ;
        endcase
      end
      if (out_rsp.valid && out_rsp.ready) begin
        if (due_results.size() == 0) begin
          $error("result arrived with no request awaiting it");
          mismatches++;
        end else begin
          want = due_results.pop_front();
          compare_result(want, out_rsp.data);
          checked++;
        end
      end
      if (in_req.valid && in_req.ready) due_results.push_back(advance_read_job(in_req.data));
    end
    in_flight <= due_results.size();
  end

endmodule

/* dv/sector_read_retry_sequencer_test.sv */
module sector_read_retry_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import srrs_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int PHASES = 6;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic clk;
  logic rst_n;

  srrs_in_if  in_req();
  srrs_out_if out_rsp();
  srrs_cfg_if cfg_wr();

  int in_flight;
  int fail_count;
  int results_checked;
  int retries_seen;
  int items_sent = 0;
  int settings_used = 1;
  int cycles = 0;
  bit calm = 1'b0;
  logic [7:0] cur_tmo = TIMEOUT_RESET;
  logic [7:0] cur_cd = COOLDOWN_RESET;

  sector_read_retry_sequencer u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cfg_wr  (cfg_wr)
  );

  srrs_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_req          (in_req),
    .out_rsp         (out_rsp),
    .cfg_wr          (cfg_wr),
    .in_flight       (in_flight),
    .fail_count      (fail_count),
    .results_checked (results_checked),
    .retries_seen    (retries_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int hold;
    int r;
    out_rsp.ready <= 1'b1;
    forever begin
      hold = $urandom_range(1, 30);
      repeat (hold) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r >= 25) begin
        out_rsp.ready <= 1'b0;
        hold = (r < 92) ? $urandom_range(1, 3) : $urandom_range(15, 50);
        repeat (hold) @(posedge clk);
        out_rsp.ready <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic srrs_in_t random_fields();
    srrs_in_t req;
    req.operation = 3'($urandom_range(0, 7));
    req.sector_count = 16'($urandom);
    req.buffer_address = $urandom;
    req.read_mode = 8'($urandom);
    req.attempt_limit = 8'($urandom);
    req.start_sector = 19'($urandom);
    req.drive_error = 1'($urandom);
    return req;
  endfunction

  function automatic srrs_in_t make_start(logic [15:0] count, logic [31:0] addr,
                                          logic [7:0] mode, logic [7:0] limit,
                                          logic [18:0] first);
    srrs_in_t req;
    req = random_fields();
    req.operation = OP_START;
    req.sector_count = count;
    req.buffer_address = addr;
    req.read_mode = mode;
    req.attempt_limit = limit;
    req.start_sector = first;
    return req;
  endfunction

  function automatic srrs_in_t start_req();
    srrs_in_t req;
    int r;
    req = random_fields();
    req.operation = OP_START;
    r = $urandom_range(0, 99);
    if (r < 70) req.sector_count = 16'($urandom_range(1, 6));
    else if (r < 80) req.sector_count = 16'($urandom_range(7, 40));
    else if (r < 90) req.sector_count = 16'($urandom_range(1, 65535));
    else if (r < 95) req.sector_count = 16'hFFFF;
    else req.sector_count = '0;
    r = $urandom_range(0, 99);
    if (r < 60) req.attempt_limit = 8'($urandom_range(1, 3));
    else if (r < 85) req.attempt_limit = 8'($urandom_range(4, 10));
    else if (r < 94) req.attempt_limit = 8'($urandom_range(0, 255));
    else if (r < 97) req.attempt_limit = 8'hFF;
    else req.attempt_limit = '0;
    r = $urandom_range(0, 99);
    if (r >= 60 && r < 80) req.buffer_address = 32'hFFFF_FFFF - $urandom_range(0, 4095);
    else if (r >= 80 && r < 90) req.buffer_address = '0;
    r = $urandom_range(0, 99);
    if (r >= 65 && r < 85) req.start_sector = 19'h7FFFF - 19'($urandom_range(0, 3));
    else if (r >= 85) req.start_sector = 19'($urandom_range(0, 3));
    return req;
  endfunction

  task automatic send_req(input srrs_in_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.data <= req;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_op(input logic [2:0] op);
    srrs_in_t req;
    req = random_fields();
    req.operation = op;
    send_req(req);
  endtask

  task automatic tick_burst(input int n);
    repeat (n) send_op(OP_TICK);
  endtask

  task automatic drain();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_wr.valid <= 1'b1;
    cfg_wr.data <= {idx, val};
    @(posedge clk);
    while (!cfg_wr.ready) @(posedge clk);
  endtask

  task automatic set_registers(input int phase);
    logic [7:0] tmo;
    logic [7:0] cd;
    logic       ntf;
    case (phase)
      0: begin
        tmo = 8'd1;
        cd = 8'd0;
        ntf = 1'b1;
      end
      1: begin
        tmo = 8'd255;
        cd = 8'd255;
        ntf = 1'b0;
      end
      2: begin
        tmo = 8'd254;
        cd = 8'd3;
        ntf = 1'b1;
      end
      3: begin
        tmo = 8'd5;
        cd = 8'd2;
        ntf = 1'b0;
      end
      default: begin
        tmo = 8'($urandom_range(1, 12));
        cd = 8'($urandom_range(0, 8));
        ntf = 1'($urandom);
      end
    endcase
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_COOLDOWN, cd);
    write_reg(REG_NOTIFY, {7'($urandom), ntf});
    cfg_wr.valid <= 1'b0;
    cur_tmo = tmo;
    cur_cd = cd;
    settings_used++;
  endtask

  task automatic run_job(input bit long_wait);
    srrs_in_t req;
    int steps;
    int span;
    int r;
    calm = ($urandom_range(0, 5) == 0);
    if (long_wait) begin
      // hold the timer past saturation before polling
      send_op(OP_BREAK);
      req = start_req();
      req.sector_count = 16'd3;
      req.attempt_limit = 8'd2;
      send_req(req);
      tick_burst($urandom_range(256, 262));
      send_op(OP_POLL);
    end else begin
      send_req(start_req());
    end
    steps = $urandom_range(4, 30);
    span = (cur_tmo < 12 ? int'(cur_tmo) : 12) + (cur_cd < 12 ? int'(cur_cd) : 12) + 2;
    repeat (steps) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_op(OP_READY);
      end else if (r < 52) begin
        send_op(OP_ERROR);
      end else if (r < 68) begin
        tick_burst($urandom_range(1, span));
        if ($urandom_range(0, 9) < 6) send_op(OP_POLL);
      end else if (r < 80) begin
        send_op(OP_POLL);
      end else if (r < 84) begin
        send_op(OP_BREAK);
      end else if (r < 88) begin
        send_req(start_req());
      end else if (r < 91) begin
        drain();
      end else begin
        send_req(random_fields());
      end
    end
  endtask

  initial begin
    srrs_in_t req;
    int base;
    bit want_long;
    rst_n <= 1'b0;
    in_req.valid <= 1'b0;
    in_req.data <= '0;
    cfg_wr.valid <= 1'b0;
    cfg_wr.data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(OP_POLL);
    send_op(OP_TICK);
    send_op(OP_READY);
    send_op(OP_ERROR);
    send_op(OP_BREAK);
    send_op(OP_SPARE_LO);
    send_op(OP_SPARE_HI);
    send_req(make_start(16'd0, 32'h0000_1000, 8'h00, 8'd3, 19'd10));
    send_req(make_start(16'd5, 32'h0000_1000, 8'h00, 8'd0, 19'd10));
    send_req(make_start(16'd2, 32'hFFFF_F800, 8'h20, 8'd1, 19'h7FFFE));
    send_req(make_start(16'd4, 32'h0000_0000, 8'h00, 8'd1, 19'd0));
    req = random_fields();
    req.operation = OP_POLL;
    req.drive_error = 1'b1;
    send_req(req);
    send_op(OP_READY);
    send_op(OP_READY);
    send_op(OP_READY);
    send_req(make_start(16'hFFFF, 32'h0000_0000, 8'hDF, 8'hFF, 19'd0));
    send_op(OP_ERROR);
    send_op(OP_READY);
    send_op(OP_BREAK);
    send_op(OP_POLL);
    send_req(make_start(16'd3, 32'h0000_1000, 8'hFF, 8'd1, 19'd100));
    send_op(OP_BREAK);
    send_op(OP_READY);
    send_op(OP_ERROR);
    send_req(make_start(16'd1, 32'hFFFF_FFFC, 8'h00, 8'd2, 19'h7FFFF));

    base = items_sent;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      set_registers(p);
      want_long = (p == 2);
      while (items_sent - base < (p + 1) * RANDOM_ITEMS / PHASES) begin
        run_job(want_long);
        want_long = 1'b0;
      end
    end
    calm = 1'b0;
    drain();

    $display("Ran %0d requests under %0d register settings: %0d results compared, %0d retries.",
             items_sent, settings_used, results_checked, retries_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/srrs_pkg.sv
hw/rtl/srrs_ifs.sv
hw/rtl/srrs_cfg_regs.sv
hw/rtl/srrs_engine.sv
hw/rtl/sector_read_retry_sequencer.sv
hw/rtl/srrs_checker.sv
dv/srrs_result_checker.sv
dv/sector_read_retry_sequencer_test.sv
